@@ hdl/sqvg_pkg.sv @@
// ----------------------------------------------------------------------------
// sqvg_pkg
// Types, widths and constants shared by the sprite quad vertex generator.
// ----------------------------------------------------------------------------
package sqvg_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  localparam int XY_W   = 34;  // CORDIC x/y, Q2.30 with headroom
  localparam int Z_W    = 26;  // angle, Q10.16 degrees, within +-180
  localparam int TRIG_W = 20;  // sin/cos, Q4.16
  localparam int PROD_W = 52;  // scale * trig
  localparam int ACC_W  = 55;  // corner accumulator, Q.33
  localparam int RND_SH = 17;

  typedef logic signed [XY_W-1:0]   xy_t;
  typedef logic signed [Z_W-1:0]    z_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam xy_t GAIN_Q30 = xy_t'(652032875);
  localparam z_t  DEG90    = z_t'(90 * 65536);
  localparam z_t  DEG180   = z_t'(180 * 65536);
  localparam z_t  DEG360   = z_t'(360 * 65536);

  typedef enum logic [1:0] {
    CORNER_TL,
    CORNER_TR,
    CORNER_BR,
    CORNER_BL
  } corner_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] angle_deg;
    logic [31:0]        color_rgba;
    logic [63:0]        tex_key;
    logic [31:0]        corner_uv0;
    logic [31:0]        corner_uv1;
    logic [31:0]        corner_uv2;
    logic [31:0]        corner_uv3;
  } sprite_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [31:0]        vertex_color;
    logic [31:0]        vertex_uv;
    logic [63:0]        vertex_tex_key;
    corner_t            corner_index;
    logic               last_corner;
  } vertex_t;

  // rotation state handed from cell to cell
  typedef struct packed {
    xy_t  x;
    xy_t  y;
    z_t   z;
    logic neg_cos;
  } rot_t;

  // atan(2^-i) in degrees, Q10.16
  function automatic z_t atan_deg(input int unsigned i);
    z_t r;
    case (i)
      0:       r = z_t'(2949120);
      1:       r = z_t'(1740967);
      2:       r = z_t'(919879);
      3:       r = z_t'(466945);
      4:       r = z_t'(234379);
      5:       r = z_t'(117304);
      6:       r = z_t'(58666);
      7:       r = z_t'(29335);
      8:       r = z_t'(14668);
      9:       r = z_t'(7334);
      10:      r = z_t'(3667);
      11:      r = z_t'(1833);
      12:      r = z_t'(917);
      13:      r = z_t'(458);
      14:      r = z_t'(229);
      15:      r = z_t'(115);
      16:      r = z_t'(57);
      17:      r = z_t'(29);
      18:      r = z_t'(14);
      19:      r = z_t'(7);
      20:      r = z_t'(4);
      21:      r = z_t'(2);
      22:      r = z_t'(1);
      default: r = z_t'(0);
    endcase
    return r;
  endfunction

endpackage

@@ hdl/sqvg_stream_if.sv @@
// ----------------------------------------------------------------------------
// sqvg_stream_if
// Valid/ready stream carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface sqvg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/sqvg_angle_reduce.sv @@
// ----------------------------------------------------------------------------
// sqvg_angle_reduce
// Reduces the angle to [-180, 180) degrees, folds it into [-90, 90] and
// loads the initial rotation state. Four register stages.
// ----------------------------------------------------------------------------
module sqvg_angle_reduce (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  sqvg_pkg::sprite_t pay_in,
  output logic              v_out,
  output sqvg_pkg::rot_t    rot_out,
  output sqvg_pkg::sprite_t pay_out
);

  // 360 degrees = 45 * 2^19 in Q16.16
  localparam logic [13:0] TURN_COARSE = 14'd45;
  localparam logic [10:0] RECIP_45    = 11'd1456;  // floor(2^16 / 45)
  localparam logic [5:0]  TOP_COARSE  = 6'd44;

  logic [12:0] a_in;
  logic [23:0] a_prod;

  logic              v1, v2, v3;
  logic [12:0]       a1;
  logic [7:0]        t1;
  logic [18:0]       lo1, lo2;
  logic [5:0]        m2;
  sqvg_pkg::z_t      r3;
  sqvg_pkg::sprite_t pay1, pay2, pay3;

  logic [13:0]  rem;
  logic [6:0]   rem2;
  logic [5:0]   m_next;
  sqvg_pkg::z_t rr;
  sqvg_pkg::z_t r_next;
  sqvg_pkg::rot_t rot_next;

  // coarse turn count offset by 4096, which is 1 mod 45
  assign a_in   = {~pay_in.angle_deg[31], pay_in.angle_deg[30:19]};
  assign a_prod = 24'(a_in) * 24'(RECIP_45);

  always_comb begin
    rem    = 14'(a1) - 14'(t1) * TURN_COARSE;
    rem2   = (rem >= TURN_COARSE) ? 7'(rem - TURN_COARSE) : 7'(rem);
    m_next = (rem2 == 7'd0) ? TOP_COARSE : 6'(rem2 - 7'd1);
  end

  always_comb begin
    rr     = sqvg_pkg::z_t'({1'b0, m2, lo2});
    r_next = (rr >= sqvg_pkg::DEG180) ? rr - sqvg_pkg::DEG360 : rr;
  end

  always_comb begin
    rot_next.x       = sqvg_pkg::GAIN_Q30;
    rot_next.y       = '0;
    rot_next.z       = r3;
    rot_next.neg_cos = 1'b0;
    if (r3 > sqvg_pkg::DEG90) begin
      rot_next.z       = sqvg_pkg::DEG180 - r3;
      rot_next.neg_cos = 1'b1;
    end else if (r3 < -sqvg_pkg::DEG90) begin
      rot_next.z       = -sqvg_pkg::DEG180 - r3;
      rot_next.neg_cos = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v1    <= v_in;
      v2    <= v1;
      v3    <= v2;
      v_out <= v3;
    end
    if (en) begin
      a1      <= a_in;
      t1      <= a_prod[23:16];
      lo1     <= pay_in.angle_deg[18:0];
      pay1    <= pay_in;
      m2      <= m_next;
      lo2     <= lo1;
      pay2    <= pay1;
      r3      <= r_next;
      pay3    <= pay2;
      rot_out <= rot_next;
      pay_out <= pay3;
    end
  end

endmodule

@@ hdl/sqvg_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// sqvg_cordic_cell
// One rotation-mode CORDIC iteration with its own shift and atan constant.
// ----------------------------------------------------------------------------
module sqvg_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  sqvg_pkg::rot_t    rot_in,
  input  sqvg_pkg::sprite_t pay_in,
  output logic              v_out,
  output sqvg_pkg::rot_t    rot_out,
  output sqvg_pkg::sprite_t pay_out
);

  localparam sqvg_pkg::z_t ATAN = sqvg_pkg::atan_deg(IDX);

  sqvg_pkg::xy_t  dx, dy;
  sqvg_pkg::rot_t rot_next;

  always_comb begin
    dx       = rot_in.y >>> IDX;
    dy       = rot_in.x >>> IDX;
    rot_next = rot_in;
    if (rot_in.z >= 0) begin
      rot_next.x = rot_in.x - dx;
      rot_next.y = rot_in.y + dy;
      rot_next.z = rot_in.z - ATAN;
    end else begin
      rot_next.x = rot_in.x + dx;
      rot_next.y = rot_in.y - dy;
      rot_next.z = rot_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      rot_out <= rot_next;
      pay_out <= pay_in;
    end
  end

endmodule

@@ hdl/sqvg_corner_unit.sv @@
// ----------------------------------------------------------------------------
// sqvg_corner_unit
// Rounds sine and cosine, forms the scale products and emits the four
// corners of the quad, one per transfer. Drives the pipeline advance.
// ----------------------------------------------------------------------------
module sqvg_corner_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 v_in,
  input  sqvg_pkg::rot_t       rot_in,
  input  sqvg_pkg::sprite_t    pay_in,
  output logic                 en,
  sqvg_stream_if.source        vertex
);

  localparam int            SH_W = sqvg_pkg::ACC_W - sqvg_pkg::RND_SH;
  localparam sqvg_pkg::xy_t TRIG_RND  = sqvg_pkg::xy_t'(8192);
  localparam sqvg_pkg::acc_t POS_RND  = sqvg_pkg::acc_t'(65536);

  // trig stage
  logic              vt;
  sqvg_pkg::trig_t   cos_t, sin_t;
  sqvg_pkg::sprite_t pay_t;

  // product stage
  logic              vp;
  sqvg_pkg::prod_t   p_xc, p_ys, p_xs, p_yc;
  sqvg_pkg::acc_t    bias_x, bias_y;
  sqvg_pkg::sprite_t pay_p;

  sqvg_pkg::corner_t k;
  logic              ov;
  sqvg_pkg::vertex_t out_q;

  sqvg_pkg::xy_t   xr, yr;
  sqvg_pkg::trig_t cos_next;
  logic            load, release_p;
  sqvg_pkg::acc_t  acc_x, acc_y;
  sqvg_pkg::vertex_t out_next;

  function automatic sqvg_pkg::acc_t signed_term(input sqvg_pkg::prod_t p,
                                                 input logic neg);
    sqvg_pkg::acc_t e;
    e = sqvg_pkg::acc_t'(p);
    return neg ? -e : e;
  endfunction

  function automatic logic signed [31:0] round_sat(input sqvg_pkg::acc_t a);
    logic signed [SH_W-1:0] s;
    s = a[sqvg_pkg::ACC_W-1:sqvg_pkg::RND_SH];
    if (s[SH_W-1:31] == '0 || s[SH_W-1:31] == '1) begin
      return s[31:0];
    end
    return s[SH_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  assign load      = vp && (!ov || vertex.ready);
  assign release_p = load && (k == sqvg_pkg::CORNER_BL);
  assign en        = !vp || release_p;

  always_comb begin
    xr       = rot_in.x + TRIG_RND;
    yr       = rot_in.y + TRIG_RND;
    cos_next = xr[sqvg_pkg::XY_W-1:14];
    if (rot_in.neg_cos) begin
      cos_next = -cos_next;
    end
  end

  always_comb begin
    acc_x = signed_term(p_xc, k == sqvg_pkg::CORNER_TL || k == sqvg_pkg::CORNER_BL)
          + signed_term(p_ys, k == sqvg_pkg::CORNER_TL || k == sqvg_pkg::CORNER_TR)
          + bias_x;
    acc_y = signed_term(p_xs, k == sqvg_pkg::CORNER_TL || k == sqvg_pkg::CORNER_BL)
          + signed_term(p_yc, k == sqvg_pkg::CORNER_BR || k == sqvg_pkg::CORNER_BL)
          + bias_y;
    out_next.vertex_x       = round_sat(acc_x);
    out_next.vertex_y       = round_sat(acc_y);
    out_next.vertex_z       = pay_p.pos_z;
    out_next.vertex_color   = pay_p.color_rgba;
    out_next.vertex_tex_key = pay_p.tex_key;
    out_next.corner_index   = k;
    out_next.last_corner    = (k == sqvg_pkg::CORNER_BL);
    case (k)
      sqvg_pkg::CORNER_TL: out_next.vertex_uv = pay_p.corner_uv0;
      sqvg_pkg::CORNER_TR: out_next.vertex_uv = pay_p.corner_uv1;
      sqvg_pkg::CORNER_BR: out_next.vertex_uv = pay_p.corner_uv2;
      default:             out_next.vertex_uv = pay_p.corner_uv3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
      vp <= 1'b0;
      k  <= sqvg_pkg::CORNER_TL;
      ov <= 1'b0;
    end else begin
      if (en) begin
        vt <= v_in;
        vp <= vt;
      end
      if (load) begin
        k  <= sqvg_pkg::corner_t'(k + 2'd1);
        ov <= 1'b1;
      end else if (vertex.ready) begin
        ov <= 1'b0;
      end
    end
    if (en) begin
      cos_t  <= cos_next;
      sin_t  <= yr[sqvg_pkg::XY_W-1:14];
      pay_t  <= pay_in;
      p_xc   <= pay_t.scale_x * cos_t;
      p_ys   <= pay_t.scale_y * sin_t;
      p_xs   <= pay_t.scale_x * sin_t;
      p_yc   <= pay_t.scale_y * cos_t;
      bias_x <= (sqvg_pkg::acc_t'(pay_t.pos_x) <<< sqvg_pkg::RND_SH) + POS_RND;
      bias_y <= (sqvg_pkg::acc_t'(pay_t.pos_y) <<< sqvg_pkg::RND_SH) + POS_RND;
      pay_p  <= pay_t;
    end
    if (load) begin
      out_q <= out_next;
    end
  end

  assign vertex.valid = ov;
  assign vertex.data  = out_q;

endmodule

@@ hdl/sprite_quad_vertex_generator_top.sv @@
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator_top
// Scales, rotates and translates a unit square into four sprite vertices.
// ----------------------------------------------------------------------------
// Each sprite transfer yields four vertex transfers, top-left, top-right,
// bottom-right, bottom-left, one per cycle while the vertex side is ready;
// the sprite side waits while the corner unit walks the four corners of one
// sprite over the single vertex channel. Sprites pass through the angle
// reduction (4 stages), a row of CORDIC_STAGES cells and the trig and
// product stages, all of which hold while the corner unit is still walking
// the corners of an earlier sprite; the first vertex of each sprite is then
// loaded into the output register of the corner unit.
// Back-pressure on the vertex side stalls the whole pipeline together.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generator_top #(
  parameter int CORDIC_STAGES = sqvg_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sqvg_stream_if.sink   sprite,
  sqvg_stream_if.source vertex
);

  logic              en;
  logic              v_c   [CORDIC_STAGES+1];
  sqvg_pkg::rot_t    rot_c [CORDIC_STAGES+1];
  sqvg_pkg::sprite_t pay_c [CORDIC_STAGES+1];

  assign sprite.ready = en;

  sqvg_angle_reduce u_reduce (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .v_in    (sprite.valid),
    .pay_in  (sprite.data),
    .v_out   (v_c[0]),
    .rot_out (rot_c[0]),
    .pay_out (pay_c[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    sqvg_cordic_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .v_in    (v_c[i]),
      .rot_in  (rot_c[i]),
      .pay_in  (pay_c[i]),
      .v_out   (v_c[i+1]),
      .rot_out (rot_c[i+1]),
      .pay_out (pay_c[i+1])
    );
  end

  sqvg_corner_unit u_corner (
    .clk    (clk),
    .rst    (rst),
    .v_in   (v_c[CORDIC_STAGES]),
    .rot_in (rot_c[CORDIC_STAGES]),
    .pay_in (pay_c[CORDIC_STAGES]),
    .en     (en),
    .vertex (vertex)
  );

endmodule

@@ hdl/sqvg_checker.sv @@
// ----------------------------------------------------------------------------
// sqvg_checker
// Port-level checks on corner order, vertex accounting, output hold and reset.
// ----------------------------------------------------------------------------
module sqvg_checker (
  input logic              clk,
  input logic              rst,
  input logic              s_valid,
  input logic              s_ready,
  input logic              v_valid,
  input logic              v_ready,
  input sqvg_pkg::vertex_t v_data
);

  logic [7:0]        pending;
  sqvg_pkg::corner_t exp_idx;
  logic              s_xfer, v_xfer;

  assign s_xfer = s_valid && s_ready;
  assign v_xfer = v_valid && v_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      exp_idx <= sqvg_pkg::CORNER_TL;
    end else begin
      pending <= pending + (s_xfer ? 8'd4 : 8'd0) - (v_xfer ? 8'd1 : 8'd0);
      if (v_xfer) begin
        exp_idx <= sqvg_pkg::corner_t'(exp_idx + 2'd1);
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v_valid && !v_ready |=> v_valid && $stable(v_data))
    else $error("vertex changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    v_valid |-> v_data.corner_index == exp_idx)
    else $error("corner out of order");

  a_owed: assert property (@(posedge clk) disable iff (rst)
    v_valid |-> pending != 8'd0)
    else $error("vertex without a sprite");

  a_reset: assert property (@(posedge clk)
    rst |=> !v_valid)
    else $error("vertex valid after reset");

endmodule

bind sprite_quad_vertex_generator_top sqvg_checker u_sqvg_checker (
  .clk     (clk),
  .rst     (rst),
  .s_valid (sprite.valid),
  .s_ready (sprite.ready),
  .v_valid (vertex.valid),
  .v_ready (vertex.ready),
  .v_data  (vertex.data)
);

@@ verif/sprite_quad_vertex_generator_top_tb.sv @@
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator_top_tb
// Self-checking bench for the sprite quad vertex generator.
// ----------------------------------------------------------------------------
// Sprites go in over the sprite stream with random gaps, and the vertex stream
// is stalled at random. A cycle-free model of the CORDIC and corner maths
// predicts the four vertices of every accepted sprite, and each vertex transfer
// is checked field by field against the oldest prediction. Directed sprites
// cover extreme fields, saturation, mirroring and the angle folds; random
// sprites follow, with one stretch where neither side idles.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generator_top_tb;

  localparam int     TRIG_STAGES  = (sqvg_pkg::CORDIC_STAGES_DEF > 24) ? 24 :
                                    sqvg_pkg::CORDIC_STAGES_DEF;
  localparam int     DRAIN_CYCLES = sqvg_pkg::CORDIC_STAGES_DEF + 16;
  localparam int     QUIET_LIMIT  = 2000;
  localparam int     Q16_ONE      = 65536;
  localparam longint TURN_Q16     = longint'(360) * 65536;
  localparam longint HALF_Q16     = longint'(180) * 65536;
  localparam longint QUART_Q16    = longint'(90) * 65536;
  localparam longint CORDIC_K     = 652032875;
  localparam longint S32_MAX      = 2147483647;
  localparam longint S32_MIN      = -longint'(2147483647) - 1;

  logic clk;
  logic rst;

  sqvg_stream_if #(.T(sqvg_pkg::sprite_t)) sprite_if ();
  sqvg_stream_if #(.T(sqvg_pkg::vertex_t)) vertex_if ();

  sprite_quad_vertex_generator_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .sprite (sprite_if),
    .vertex (vertex_if)
  );

  // atan(2^-i) in degrees, Q16.16
  longint atan_q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  sqvg_pkg::vertex_t pending_vertices [$];
  int                mismatch_count;
  int                idle_pct;
  int                quiet_cycles;
  sqvg_pkg::vertex_t got_v;
  sqvg_pkg::vertex_t want_v;
  string             bad_fields;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---- prediction ----------------------------------------------------------

  function automatic void cordic_sin_cos(input logic [31:0] ang, output longint sn,
                                         output longint cs);
    longint r, x, y, z, dx, dy;
    bit     flip;
    int     i;
    r    = longint'($signed(ang)) % TURN_Q16;
    flip = 1'b0;
    if (r < 0) r += TURN_Q16;
    if (r >= HALF_Q16) r -= TURN_Q16;
    if (r > QUART_Q16) begin
      r    = HALF_Q16 - r;
      flip = 1'b1;
    end else if (r < -QUART_Q16) begin
      r    = -HALF_Q16 - r;
      flip = 1'b1;
    end
    x = CORDIC_K;
    y = 0;
    z = r;
    for (i = 0; i < TRIG_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_q16[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_q16[i];
      end
    end
    cs = (x + 8192) >>> 14;
    sn = (y + 8192) >>> 14;
    if (flip) cs = -cs;
  endfunction

  function automatic logic [31:0] round_sat_q33(input longint acc);
    longint v;
    v = (acc + 65536) >>> 17;
    if (v > S32_MAX) return 32'h7fff_ffff;
    if (v < S32_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void predict_quad(input sqvg_pkg::sprite_t s);
    longint            sn, cs, ax, ay, sx, sy;
    sqvg_pkg::vertex_t v;
    sqvg_pkg::corner_t k;
    cordic_sin_cos(s.angle_deg, sn, cs);
    for (int n = 0; n < 4; n++) begin
      k  = sqvg_pkg::corner_t'(n);
      sx = (k == sqvg_pkg::CORNER_TL || k == sqvg_pkg::CORNER_BL) ? -1 : 1;
      sy = (k == sqvg_pkg::CORNER_TL || k == sqvg_pkg::CORNER_TR) ? 1 : -1;
      ax = sx * longint'($signed(s.scale_x));
      ay = sy * longint'($signed(s.scale_y));
      v.vertex_x       = round_sat_q33(ax * cs - ay * sn +
                                       longint'($signed(s.pos_x)) * 131072);
      v.vertex_y       = round_sat_q33(ax * sn + ay * cs +
                                       longint'($signed(s.pos_y)) * 131072);
      v.vertex_z       = s.pos_z;
      v.vertex_color   = s.color_rgba;
      v.vertex_tex_key = s.tex_key;
      case (k)
        sqvg_pkg::CORNER_TL: v.vertex_uv = s.corner_uv0;
        sqvg_pkg::CORNER_TR: v.vertex_uv = s.corner_uv1;
        sqvg_pkg::CORNER_BR: v.vertex_uv = s.corner_uv2;
        default:             v.vertex_uv = s.corner_uv3;
      endcase
      v.corner_index = k;
      v.last_corner  = (k == sqvg_pkg::CORNER_BL);
      pending_vertices = {pending_vertices, v};
    end
  endfunction

  // ---- stimulus helpers ----------------------------------------------------

  function automatic logic [31:0] rand_q16();
    logic [31:0] w;
    case ($urandom_range(4))
      0: w = $urandom;
      1: w = {{12{1'($urandom_range(1))}}, 20'($urandom)};
      2: w = 32'($signed(int'($urandom_range(8 * Q16_ONE)) - 4 * Q16_ONE));
      3: w = {{6{1'($urandom_range(1))}}, 26'($urandom)};
      default: begin
        case ($urandom_range(4))
          0: w = 32'h7fff_ffff;
          1: w = 32'h8000_0000;
          2: w = 32'h0000_0000;
          3: w = 32'hffff_ffff;
          default: w = 32'h0000_0001;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic sqvg_pkg::sprite_t rand_sprite();
    sqvg_pkg::sprite_t s;
    s.pos_x      = rand_q16();
    s.pos_y      = rand_q16();
    s.pos_z      = $urandom;
    s.scale_x    = rand_q16();
    s.scale_y    = rand_q16();
    s.angle_deg  = ($urandom_range(2) == 0) ? $urandom :
                   32'(int'($urandom_range(1440 * Q16_ONE)) - 720 * Q16_ONE);
    s.color_rgba = $urandom;
    s.tex_key    = {$urandom, $urandom};
    s.corner_uv0 = $urandom;
    s.corner_uv1 = $urandom;
    s.corner_uv2 = $urandom;
    s.corner_uv3 = $urandom;
    return s;
  endfunction

  function automatic sqvg_pkg::sprite_t plain_sprite(input int deg);
    sqvg_pkg::sprite_t s;
    s           = rand_sprite();
    s.pos_x     = 32'(10 * Q16_ONE);
    s.pos_y     = 32'(-20 * Q16_ONE);
    s.scale_x   = 32'(16 * Q16_ONE);
    s.scale_y   = 32'(8 * Q16_ONE);
    s.angle_deg = 32'(deg * Q16_ONE);
    return s;
  endfunction

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_sprite(input sqvg_pkg::sprite_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      sprite_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sprite_if.data  <= s;
    sprite_if.valid <= 1'b1;
    do @(posedge clk); while (!sprite_if.ready);
    predict_quad(s);
  endtask

  // ---- tests ---------------------------------------------------------------

  task automatic test_extremes();
    sqvg_pkg::sprite_t s;
    s = '0;
    send_sprite(s);
    s = plain_sprite(0);
    s.pos_x   = 32'h7fff_ffff;
    s.pos_y   = 32'h7fff_ffff;
    s.scale_x = 32'h7fff_ffff;
    s.scale_y = 32'h7fff_ffff;
    s.pos_z   = 32'h7fff_ffff;
    s.color_rgba = '1;
    s.tex_key    = '1;
    s.corner_uv0 = '1;
    s.corner_uv1 = '1;
    s.corner_uv2 = '1;
    s.corner_uv3 = '1;
    send_sprite(s);
    s = plain_sprite(0);
    s.pos_x   = 32'h8000_0000;
    s.pos_y   = 32'h8000_0000;
    s.pos_z   = 32'h8000_0000;
    s.scale_x = 32'h7fff_ffff;
    s.scale_y = 32'h7fff_ffff;
    send_sprite(s);
    s = plain_sprite(45);
    s.scale_x    = 32'h8000_0000;
    s.scale_y    = 32'h8000_0000;
    s.color_rgba = 32'haaaa_aaaa;
    s.tex_key    = 64'h5555_5555_aaaa_aaaa;
    s.corner_uv0 = 32'h5555_aaaa;
    s.corner_uv1 = 32'haaaa_5555;
    s.corner_uv2 = 32'h8000_7fff;
    s.corner_uv3 = 32'h7fff_8000;
    send_sprite(s);
    // mirrored quad
    s = plain_sprite(30);
    s.scale_x = 32'(-2 * Q16_ONE);
    s.scale_y = 32'(3 * Q16_ONE);
    send_sprite(s);
    s = plain_sprite(-60);
    s.scale_x = 32'(-5 * Q16_ONE);
    s.scale_y = 32'(-7 * Q16_ONE);
    send_sprite(s);
  endtask

  task automatic test_angle_folds();
    int                degs [12] = '{0, 90, -90, 180, -180, 270, -270, 360, 720, 45,
                                     -135, 135};
    sqvg_pkg::sprite_t s;
    foreach (degs[i]) send_sprite(plain_sprite(degs[i]));
    s = plain_sprite(90);
    s.angle_deg = s.angle_deg + 1;
    send_sprite(s);
    s = plain_sprite(-90);
    s.angle_deg = s.angle_deg - 1;
    send_sprite(s);
    s.angle_deg = 32'h7fff_ffff;
    send_sprite(s);
    s.angle_deg = 32'h8000_0000;
    send_sprite(s);
  endtask

  task automatic test_random_sprites();
    for (int n = 0; n < 78; n++) begin
      idle_pct = (n >= 30 && n < 55) ? 0 : 30;
      send_sprite(rand_sprite());
    end
    idle_pct = 30;
  endtask

  // ---- vertex side ---------------------------------------------------------

  always @(negedge clk) vertex_if.ready <= ($urandom_range(99) >= idle_pct);

  task automatic note_mismatch(input string what, input sqvg_pkg::vertex_t want,
                               input sqvg_pkg::vertex_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %0d: %s", mismatch_count, what);
      $display("  expected x=%h y=%h z=%h col=%h uv=%h key=%h idx=%0d last=%b",
               want.vertex_x, want.vertex_y, want.vertex_z, want.vertex_color,
               want.vertex_uv, want.vertex_tex_key, want.corner_index, want.last_corner);
      $display("  actual   x=%h y=%h z=%h col=%h uv=%h key=%h idx=%0d last=%b",
               got.vertex_x, got.vertex_y, got.vertex_z, got.vertex_color,
               got.vertex_uv, got.vertex_tex_key, got.corner_index, got.last_corner);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && vertex_if.valid && vertex_if.ready) begin
      got_v = vertex_if.data;
      if (pending_vertices.size() == 0) begin
        note_mismatch("vertex transfer with nothing pending", '0, got_v);
      end else begin
        want_v     = pending_vertices.pop_front();
        bad_fields = "";
        if (got_v.vertex_x !== want_v.vertex_x) bad_fields = {bad_fields, " x"};
        if (got_v.vertex_y !== want_v.vertex_y) bad_fields = {bad_fields, " y"};
        if (got_v.vertex_z !== want_v.vertex_z) bad_fields = {bad_fields, " z"};
        if (got_v.vertex_color !== want_v.vertex_color) bad_fields = {bad_fields, " colour"};
        if (got_v.vertex_uv !== want_v.vertex_uv) bad_fields = {bad_fields, " uv"};
        if (got_v.vertex_tex_key !== want_v.vertex_tex_key) bad_fields = {bad_fields, " key"};
        if (got_v.corner_index !== want_v.corner_index) bad_fields = {bad_fields, " index"};
        if (got_v.last_corner !== want_v.last_corner) bad_fields = {bad_fields, " last"};
        if (bad_fields != "") note_mismatch({"field(s)", bad_fields}, want_v, got_v);
      end
    end
  end

  // no transfer on either side for too long ends the run
  always @(posedge clk) begin
    if (rst || (sprite_if.valid && sprite_if.ready) || (vertex_if.valid && vertex_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("** sprite_quad_vertex_generator_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    idle_pct        = 30;
    sprite_if.valid = 1'b0;
    sprite_if.data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_angle_folds();
    test_random_sprites();
    @(negedge clk);
    sprite_if.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_vertices.size() == 0) begin
      $display("** sprite_quad_vertex_generator_top: PASSED **");
    end else begin
      $display("** sprite_quad_vertex_generator_top: FAILED **");
    end
    $finish;
  end

endmodule
